@@ sv/infix_to_postfix_converter_defines.svh @@
// assertion macros shared by the checker
`ifndef INFIX_TO_POSTFIX_CONVERTER_DEFINES_SVH
`define INFIX_TO_POSTFIX_CONVERTER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define ITP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("itp check failed");

// next-cycle implication, sampled on clk, off during reset
`define ITP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("itp check failed");

`endif

@@ sv/itp_pkg.sv @@
package itp_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    // operator codes held in the stack
    typedef enum logic [2:0] {
        OP_LPAREN = 3'd0,
        OP_ADD    = 3'd1,
        OP_SUB    = 3'd2,
        OP_MUL    = 3'd3,
        OP_DIV    = 3'd4,
        OP_POW    = 3'd5
    } op_code_t;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNMATCHED = 2'd2;

    // characters
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;

    // one stack slot
    typedef struct packed {
        logic     valid;
        op_code_t code;
    } entry_t;

    // shift commands to the cell chain
    typedef struct packed {
        logic     push;
        logic     pop;
        op_code_t code;
    } stack_ctl_t;

    // what the controller sees of the stack
    typedef struct packed {
        entry_t top;
        entry_t second;
        logic   full;
    } stack_view_t;

    function automatic logic [1:0] code_prec(input op_code_t code);
        logic [1:0] p;
        begin
            unique case (code)
                OP_ADD, OP_SUB: p = 2'd1;
                OP_MUL, OP_DIV: p = 2'd2;
                OP_POW:         p = 2'd3;
                default:        p = 2'd0;
            endcase
            return p;
        end
    endfunction

    function automatic logic [7:0] code_symbol(input op_code_t code);
        logic [7:0] s;
        begin
            unique case (code)
                OP_LPAREN: s = CH_LPAREN;
                OP_ADD:    s = CH_PLUS;
                OP_SUB:    s = CH_MINUS;
                OP_MUL:    s = CH_STAR;
                OP_DIV:    s = CH_SLASH;
                OP_POW:    s = CH_CARET;
                default:   s = 8'h00;
            endcase
            return s;
        end
    endfunction

endpackage

@@ sv/itp_cell.sv @@
module itp_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  itp_pkg::stack_ctl_t ctl,
    input  itp_pkg::entry_t    from_above,
    input  itp_pkg::entry_t    from_below,
    output itp_pkg::entry_t    q
);
    import itp_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    op_code_t code_reg;
    op_code_t code_next;

    // push shifts down from the top side, pop shifts up from the bottom side
    always_comb
    begin
        valid_next = valid_reg;
        code_next  = code_reg;
        if (ctl.push)
        begin
            valid_next = from_above.valid;
            code_next  = from_above.code;
        end
        else if (ctl.pop)
        begin
            valid_next = from_below.valid;
            code_next  = from_below.code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
    end

    assign q = '{valid: valid_reg, code: code_reg};

endmodule

@@ sv/itp_ctrl.sv @@
module itp_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,
    output logic                  m_tlast,
    output logic [3:0]            m_tuser,
    input  itp_pkg::stack_view_t  view,
    output itp_pkg::stack_ctl_t   ctl
);
    import itp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LETTER,
        S_OPPOP,
        S_CLPOP,
        S_FLUSH,
        S_MARK
    } state_t;

    state_t           state_reg, state_next;
    logic [7:0]       char_reg, char_next;
    logic             last_reg, last_next;
    op_code_t         code_reg, code_next;
    logic [1:0]       prec_reg, prec_next;
    logic [1:0]       status_reg, status_next;
    logic [1:0]       err_reg, err_next;
    logic             emitted_reg, emitted_next;
    logic [CNT_W-1:0] paren_reg, paren_next;

    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_char_reg, out_char_next;
    logic             out_cvalid_reg, out_cvalid_next;
    logic             out_rlast_reg, out_rlast_next;
    logic             out_end_reg, out_end_next;
    logic [1:0]       out_status_reg, out_status_next;

    logic             out_free;
    logic             accept;
    logic             emit;
    logic [7:0]       emit_char;
    logic             emit_cvalid;
    logic             emit_rlast;
    logic             emit_end;

    // decode of the incoming character
    logic             is_letter;
    logic             is_op;
    op_code_t         in_code;
    logic [1:0]       in_prec;
    logic             top_ge;
    logic             second_ge;
    logic             second_op;
    logic [1:0]       new_err;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        is_letter = ((s_tdata >= CH_UP_A) && (s_tdata <= CH_UP_Z)) ||
                    ((s_tdata >= CH_LO_A) && (s_tdata <= CH_LO_Z));
        is_op   = 1'b1;
        in_code = OP_ADD;
        unique case (s_tdata)
            CH_PLUS:  in_code = OP_ADD;
            CH_MINUS: in_code = OP_SUB;
            CH_STAR:  in_code = OP_MUL;
            CH_SLASH: in_code = OP_DIV;
            CH_CARET: in_code = OP_POW;
            default:  is_op = 1'b0;
        endcase
        in_prec = code_prec(in_code);
    end

    // pop conditions against the top two cells
    assign top_ge    = view.top.valid && (code_prec(view.top.code) >= prec_reg);
    assign second_ge = view.second.valid && (code_prec(view.second.code) >= prec_reg);
    assign second_op = view.second.valid && (view.second.code != OP_LPAREN);

    // errors are known at accept time: first error of the expression sticks
    always_comb
    begin
        new_err = err_reg;
        if (err_reg == ST_OK)
        begin
            if (is_op && view.full &&
                !(code_prec(view.top.code) >= in_prec))
                new_err = ST_OVERFLOW;
            else if ((s_tdata == CH_LPAREN) && view.full)
                new_err = ST_OVERFLOW;
            else if ((s_tdata == CH_RPAREN) && (paren_reg == '0))
                new_err = ST_UNMATCHED;
        end
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        char_next    = char_reg;
        last_next    = last_reg;
        code_next    = code_reg;
        prec_next    = prec_reg;
        status_next  = status_reg;
        err_next     = err_reg;
        emitted_next = emitted_reg;
        paren_next   = paren_reg;
        ctl          = '{push: 1'b0, pop: 1'b0, code: code_reg};
        emit         = 1'b0;
        emit_char    = 8'h00;
        emit_cvalid  = 1'b0;
        emit_rlast   = 1'b0;
        emit_end     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    char_next    = s_tdata;
                    last_next    = s_tlast;
                    code_next    = in_code;
                    prec_next    = in_prec;
                    status_next  = new_err;
                    err_next     = s_tlast ? ST_OK : new_err;
                    emitted_next = 1'b0;
                    if (is_letter)
                        state_next = S_LETTER;
                    else if (is_op)
                        state_next = S_OPPOP;
                    else if (s_tdata == CH_RPAREN)
                        state_next = S_CLPOP;
                    else
                    begin
                        if (s_tdata == CH_LPAREN)
                        begin
                            ctl.code = OP_LPAREN;
                            ctl.push = !view.full;
                            if (!view.full)
                                paren_next = paren_reg + 1'b1;
                        end
                        state_next = s_tlast ? S_FLUSH : S_MARK;
                    end
                end
            end

            S_LETTER:
            begin
                if (out_free)
                begin
                    emit        = 1'b1;
                    emit_char   = char_reg;
                    emit_cvalid = 1'b1;
                    emit_rlast  = !last_reg;
                    state_next  = last_reg ? S_FLUSH : S_IDLE;
                end
            end

            S_OPPOP:
            begin
                if (top_ge)
                begin
                    if (out_free)
                    begin
                        ctl.pop      = 1'b1;
                        emit         = 1'b1;
                        emit_char    = code_symbol(view.top.code);
                        emit_cvalid  = 1'b1;
                        emit_rlast   = !last_reg && !second_ge;
                        emitted_next = 1'b1;
                        if (view.top.code == OP_LPAREN)
                            paren_next = paren_reg - 1'b1;
                    end
                end
                else
                begin
                    // push the new operator, dropped on a full stack
                    ctl.push   = !view.full;
                    state_next = last_reg ? S_FLUSH : (emitted_reg ? S_IDLE : S_MARK);
                end
            end

            S_CLPOP:
            begin
                if (view.top.valid && (view.top.code != OP_LPAREN))
                begin
                    if (out_free)
                    begin
                        ctl.pop      = 1'b1;
                        emit         = 1'b1;
                        emit_char    = code_symbol(view.top.code);
                        emit_cvalid  = 1'b1;
                        emit_rlast   = !last_reg && !second_op;
                        emitted_next = 1'b1;
                    end
                end
                else
                begin
                    // discard the matching opener if there is one
                    if (view.top.valid)
                    begin
                        ctl.pop    = 1'b1;
                        paren_next = paren_reg - 1'b1;
                    end
                    state_next = last_reg ? S_FLUSH : (emitted_reg ? S_IDLE : S_MARK);
                end
            end

            S_FLUSH:
            begin
                if (view.top.valid)
                begin
                    if (out_free)
                    begin
                        ctl.pop     = 1'b1;
                        emit        = 1'b1;
                        emit_char   = code_symbol(view.top.code);
                        emit_cvalid = 1'b1;
                        if (view.top.code == OP_LPAREN)
                            paren_next = paren_reg - 1'b1;
                    end
                end
                else
                    state_next = S_MARK;
            end

            S_MARK:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    emit_rlast = 1'b1;
                    emit_end   = last_reg;
                    state_next = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_char_next   = out_char_reg;
        out_cvalid_next = out_cvalid_reg;
        out_rlast_next  = out_rlast_reg;
        out_end_next    = out_end_reg;
        out_status_next = out_status_reg;
        if (emit)
        begin
            out_valid_next  = 1'b1;
            out_char_next   = emit_char;
            out_cvalid_next = emit_cvalid;
            out_rlast_next  = emit_rlast;
            out_end_next    = emit_end;
            out_status_next = status_reg;
        end
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    // state, working registers and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            err_reg        <= ST_OK;
            paren_reg      <= '0;
            out_valid_reg  <= 1'b0;
            char_reg       <= 8'h00;
            last_reg       <= 1'b0;
            code_reg       <= OP_LPAREN;
            prec_reg       <= 2'd0;
            status_reg     <= ST_OK;
            emitted_reg    <= 1'b0;
            out_char_reg   <= 8'h00;
            out_cvalid_reg <= 1'b0;
            out_rlast_reg  <= 1'b0;
            out_end_reg    <= 1'b0;
            out_status_reg <= ST_OK;
        end
        else
        begin
            state_reg      <= state_next;
            err_reg        <= err_next;
            paren_reg      <= paren_next;
            out_valid_reg  <= out_valid_next;
            char_reg       <= char_next;
            last_reg       <= last_next;
            code_reg       <= code_next;
            prec_reg       <= prec_next;
            status_reg     <= status_next;
            emitted_reg    <= emitted_next;
            out_char_reg   <= out_char_next;
            out_cvalid_reg <= out_cvalid_next;
            out_rlast_reg  <= out_rlast_next;
            out_end_reg    <= out_end_next;
            out_status_reg <= out_status_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tlast  = out_rlast_reg;
    assign m_tuser  = {out_status_reg, out_end_reg, out_cvalid_reg};

endmodule

@@ sv/infix_to_postfix_converter.sv @@
// Infix to postfix converter (shunting-yard), one character per input transfer.
// Slave channel: s_tdata carries one ASCII character, s_tlast marks the final
// character of an expression. Master channel: one transfer per postfix symbol,
// plus an empty marker (m_tuser[0] = 0) for a character that produces nothing,
// and a closing marker with m_tuser[1] set after the flush of the last
// character. m_tlast marks the final transfer caused by one input character;
// m_tuser[3:2] gives the expression's first error (overflow, stray ')').
// The operator stack is a chain of cells that shifts down on a push and up on
// a pop, one pop per cycle; a pop that emits a symbol waits while a stalled
// receiver holds the output register. An operator pops the entries of equal or
// higher precedence and then pushes itself; a ')' pops the operators above its
// '(' and then discards it. A last character then has every entry flushed, the
// stack seen empty and the closing marker sent. A push, a discard or an
// empty-stack check can come before the first result of an input.
// One input is worked on at a time; s_tready is high while the sequencer is
// idle, even when a result still waits in the output register.
// A stalled receiver holds the output register and the sequencer waits, no
// result is lost. Reset empties the stack and clears the error status; there
// is no clearing pass.
module infix_to_postfix_converter (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_char
    input  logic       s_tlast,   // last_of_expression
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_char
    output logic       m_tlast,   // run_last
    output logic [3:0] m_tuser    // [0] char_valid, [1] expression_end, [3:2] status
);
    import itp_pkg::*;

    stack_ctl_t  ctl;
    stack_view_t view;
    entry_t      cell_q     [STACK_DEPTH];
    entry_t      cell_above [STACK_DEPTH];
    entry_t      cell_below [STACK_DEPTH];

    itp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .view     (view),
        .ctl      (ctl)
    );

    // cell chain, cell 0 is the top of the stack
    genvar i;
    generate
        for (i = 0; i < STACK_DEPTH; i++)
        begin : g_cell
            if (i == 0)
            begin : g_top
                assign cell_above[i] = '{valid: 1'b1, code: ctl.code};
            end
            else
            begin : g_mid
                assign cell_above[i] = cell_q[i-1];
            end

            if (i == STACK_DEPTH - 1)
            begin : g_bottom
                assign cell_below[i] = '{valid: 1'b0, code: OP_LPAREN};
            end
            else
            begin : g_inner
                assign cell_below[i] = cell_q[i+1];
            end

            itp_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .from_above (cell_above[i]),
                .from_below (cell_below[i]),
                .q          (cell_q[i])
            );
        end
    endgenerate

    assign view = '{top: cell_q[0], second: cell_q[1],
                    full: cell_q[STACK_DEPTH-1].valid};

endmodule

@@ sv/itp_checker.sv @@
`include "infix_to_postfix_converter_defines.svh"

module itp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic       s_tlast,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic [3:0] m_tuser
);

    // stalled result holds
    `ITP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // closing marker always ends the run and carries no symbol
    `ITP_ASSERT_NOW(a_end_is_last, m_tvalid && m_tuser[1], m_tlast && !m_tuser[0])

    // markers carry a zero character
    `ITP_ASSERT_NOW(a_marker_zero, m_tvalid && !m_tuser[0], m_tdata == 8'h00)

    // status has only three codes
    `ITP_ASSERT_NOW(a_status_code, m_tvalid, m_tuser[3:2] != 2'd3)

    // one character at a time: busy after every input transfer
    `ITP_ASSERT_NEXT(a_busy_after_in, s_tvalid && s_tready, !s_tready)

endmodule

bind infix_to_postfix_converter itp_checker u_itp_checker (.*);

@@ dv/infix_to_postfix_converter_test.sv @@
`timescale 1ns / 100ps

module infix_to_postfix_converter_test;
    import itp_pkg::*;

    localparam int RANDOM_ITEMS = 250;
    localparam int TAIL_CYCLES  = 50;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int REPORT_LIMIT = 10;

    // one character on the way in
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } char_item_t;

    // one transfer on the way out, packed in monitor order
    typedef struct packed {
        logic [7:0] out_char;
        logic       char_valid;
        logic       run_last;
        logic       expr_end;
        logic [1:0] status;
    } symbol_t;

    // receiver stall patterns
    typedef enum logic [1:0] {
        RX_STREAM,
        RX_COIN,
        RX_EVERY4,
        RX_SLOW
    } rx_mode_t;

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic [3:0] m_tuser;

    char_item_t pending_chars[$];
    symbol_t    expected_symbols[$];
    symbol_t    step_symbols[$];

    // shadow operator stack
    op_code_t   op_stack[STACK_DEPTH];
    int         stack_used = 0;
    logic [1:0] expr_error = ST_OK;

    int counted_items    = 0;
    int error_count      = 0;
    int symbols_checked  = 0;
    int expressions_done = 0;
    int overflow_hits    = 0;
    int unmatched_hits   = 0;

    logic       in_taken    = 1'b0;
    int         burst_left  = 0;
    int         gap_left    = 0;
    char_item_t next_item;
    rx_mode_t   rx_mode     = RX_STREAM;
    int         window_left = 0;

    infix_to_postfix_converter dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #10 clk = ~clk;

    function automatic bit is_letter(input logic [7:0] ch);
        return (ch >= CH_UP_A && ch <= CH_UP_Z) || (ch >= CH_LO_A && ch <= CH_LO_Z);
    endfunction

    function automatic bit char_to_op(input logic [7:0] ch, output op_code_t code);
        code = OP_LPAREN;
        case (ch)
            CH_PLUS:  code = OP_ADD;
            CH_MINUS: code = OP_SUB;
            CH_STAR:  code = OP_MUL;
            CH_SLASH: code = OP_DIV;
            CH_CARET: code = OP_POW;
            default:  return 1'b0;
        endcase
        return 1'b1;
    endfunction

    // binding strength, open paren lowest so it is never popped by an operator
    function automatic int op_rank(input op_code_t code);
        case (code) inside
            OP_ADD, OP_SUB: return 1;
            OP_MUL, OP_DIV: return 2;
            OP_POW:         return 3;
            default:        return 0;
        endcase
    endfunction

    function automatic logic [7:0] op_char(input op_code_t code);
        case (code)
            OP_ADD:  return CH_PLUS;
            OP_SUB:  return CH_MINUS;
            OP_MUL:  return CH_STAR;
            OP_DIV:  return CH_SLASH;
            OP_POW:  return CH_CARET;
            default: return CH_LPAREN;
        endcase
    endfunction

    function automatic symbol_t make_symbol(input logic [7:0] ch, input logic valid);
        return '{ch, valid, 1'b0, 1'b0, ST_OK};
    endfunction

    function automatic logic [7:0] random_letter();
        if ($urandom_range(0, 1) == 0)
            return CH_UP_A + 8'($urandom_range(0, 25));
        return CH_LO_A + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] random_operator();
        case ($urandom_range(0, 4))
            0:       return CH_PLUS;
            1:       return CH_MINUS;
            2:       return CH_STAR;
            3:       return CH_SLASH;
            default: return CH_CARET;
        endcase
    endfunction

    // first error of an expression sticks
    task automatic note_error(input logic [1:0] code);
        if (code == ST_OVERFLOW)
            overflow_hits++;
        else
            unmatched_hits++;
        if (expr_error == ST_OK)
            expr_error = code;
    endtask

    task automatic push_op(input op_code_t code);
        if (stack_used < STACK_DEPTH)
        begin
            op_stack[stack_used] = code;
            stack_used++;
        end
        else
            note_error(ST_OVERFLOW);
    endtask

    task automatic pop_symbol();
        stack_used--;
        step_symbols.push_back(make_symbol(op_char(op_stack[stack_used]), 1'b1));
    endtask

    // shunting-yard step: queues every transfer caused by one input character
    task automatic convert_char(input logic [7:0] ch, input logic last);
        symbol_t  sym;
        op_code_t code;
        int       i;
        step_symbols.delete();
        if (is_letter(ch))
            step_symbols.push_back(make_symbol(ch, 1'b1));
        else if (char_to_op(ch, code))
        begin
            while (stack_used > 0 && op_rank(op_stack[stack_used - 1]) >= op_rank(code))
                pop_symbol();
            push_op(code);
        end
        else if (ch == CH_LPAREN)
            push_op(OP_LPAREN);
        else if (ch == CH_RPAREN)
        begin
            while (stack_used > 0 && op_stack[stack_used - 1] != OP_LPAREN)
                pop_symbol();
            if (stack_used > 0)
                stack_used--;
            else
                note_error(ST_UNMATCHED);
        end

        // flush on the final character, otherwise an empty marker when nothing was queued
        if (last)
        begin
            while (stack_used > 0)
                pop_symbol();
            sym = make_symbol(8'h00, 1'b0);
            sym.expr_end = 1'b1;
            step_symbols.push_back(sym);
            expressions_done++;
        end
        else if (step_symbols.size() == 0)
            step_symbols.push_back(make_symbol(8'h00, 1'b0));

        sym = step_symbols.pop_back();
        sym.run_last = 1'b1;
        step_symbols.push_back(sym);
        for (i = 0; i < step_symbols.size(); i++)
        begin
            sym = step_symbols[i];
            sym.status = expr_error;
            expected_symbols.push_back(sym);
        end
        if (last)
            expr_error = ST_OK;
    endtask

    task automatic check_symbol(input symbol_t got);
        symbol_t want;
        if (expected_symbols.size() == 0)
        begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
                $display("%0t: unexpected result char=%h valid=%b last=%b end=%b status=%0d",
                         $realtime, got.out_char, got.char_valid, got.run_last,
                         got.expr_end, got.status);
            return;
        end
        want = expected_symbols.pop_front();
        symbols_checked++;
        if (got !== want)
        begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
            begin
                $display("%0t: mismatch on result %0d", $realtime, symbols_checked);
                $display("    expected char=%h valid=%b last=%b end=%b status=%0d",
                         want.out_char, want.char_valid, want.run_last, want.expr_end,
                         want.status);
                $display("    actual   char=%h valid=%b last=%b end=%b status=%0d",
                         got.out_char, got.char_valid, got.run_last, got.expr_end,
                         got.status);
            end
        end
    endtask

    // every character sent counts toward the item budget
    task automatic add_item(input logic [7:0] ch, input logic last);
        pending_chars.push_back('{ch, last});
        counted_items++;
    endtask

    // well-formed expression with random letters, operators and nesting
    task automatic add_expression();
        int         terms;
        int         open;
        int         i;
        char_item_t tail;
        terms = $urandom_range(1, 8);
        open  = 0;
        for (i = 0; i < terms; i++)
        begin
            while (open < 6 && $urandom_range(0, 3) == 0)
            begin
                add_item(CH_LPAREN, 1'b0);
                open++;
            end
            add_item(random_letter(), 1'b0);
            while (open > 0 && $urandom_range(0, 2) == 0)
            begin
                add_item(CH_RPAREN, 1'b0);
                open--;
            end
            if (i != terms - 1)
                add_item(random_operator(), 1'b0);
        end
        while (open > 0)
        begin
            add_item(CH_RPAREN, 1'b0);
            open--;
        end
        tail = pending_chars.pop_back();
        tail.last = 1'b1;
        pending_chars.push_back(tail);
    endtask

    // two pushes per level, so more than half the stack depth overflows
    task automatic add_deep_nest(input int min_levels, input int max_levels);
        int levels;
        int i;
        levels = $urandom_range(min_levels, max_levels);
        for (i = 0; i < levels; i++)
        begin
            add_item(CH_LPAREN, 1'b0);
            add_item(random_letter(), 1'b0);
            add_item(random_operator(), 1'b0);
        end
        add_item(random_letter(), 1'b0);
        for (i = 0; i < levels - 1; i++)
            add_item(CH_RPAREN, 1'b0);
        add_item(CH_RPAREN, 1'b1);
    endtask

    // broken fragments and arbitrary bytes
    task automatic add_noise();
        int         n;
        int         i;
        logic [7:0] ch;
        n = $urandom_range(1, 6);
        for (i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 3))
                0:       ch = 8'($urandom_range(0, 255));
                1:       ch = CH_RPAREN;
                2:       ch = CH_LPAREN;
                default: ch = random_operator();
            endcase
            add_item(ch, $urandom_range(0, 5) == 0);
        end
    endtask

    // input side: bursts of transfers with random gaps
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || in_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (pending_chars.size() > 0)
            begin
                next_item = pending_chars.pop_front();
                s_tdata  <= next_item.ch;
                s_tlast  <= next_item.last;
                s_tvalid <= 1'b1;
                if (burst_left > 0)
                    burst_left--;
                else if ($urandom_range(0, 7) == 0)
                begin
                    burst_left = $urandom_range(30, 60);
                    gap_left   = 0;
                end
                else
                begin
                    burst_left = $urandom_range(0, 15);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // output side: stall pattern changes every window
    always @(negedge clk)
    begin
        if (window_left == 0)
        begin
            rx_mode     = rx_mode_t'($urandom_range(0, 3));
            window_left = $urandom_range(8, 64);
        end
        window_left--;
        case (rx_mode)
            RX_STREAM: m_tready <= 1'b1;
            RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
            RX_EVERY4: m_tready <= (window_left % 4 == 0);
            default:   m_tready <= (window_left % 16 == 0);
        endcase
    end

    // predict on each input transfer, check each output transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_taken <= 1'b0;
        else
        begin
            in_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
                convert_char(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                check_symbol({m_tdata, m_tuser[0], m_tlast, m_tuser[1], m_tuser[3:2]});
        end
    end

    initial
    begin : run_test
        int choice;
        int drain;

        // directed: letter bounds, every operator, nesting, ignored bytes, a stray ')'
        add_item(CH_UP_A, 1'b0);
        add_item(CH_PLUS, 1'b0);
        add_item(CH_UP_Z, 1'b0);
        add_item(CH_MINUS, 1'b0);
        add_item(CH_LO_A, 1'b0);
        add_item(CH_STAR, 1'b0);
        add_item(CH_LO_Z, 1'b0);
        add_item(CH_SLASH, 1'b0);
        add_item(CH_LPAREN, 1'b0);
        add_item(CH_LO_A + 8'd1, 1'b0);
        add_item(CH_CARET, 1'b0);
        add_item(CH_LO_A + 8'd2, 1'b0);
        add_item(CH_CARET, 1'b0);
        add_item(CH_LO_A + 8'd3, 1'b0);
        add_item(CH_RPAREN, 1'b0);
        add_item(8'h00, 1'b0);
        add_item(8'hFF, 1'b1);
        add_item(CH_RPAREN, 1'b0);
        add_item(CH_LO_A + 8'd4, 1'b0);
        add_item(CH_LPAREN, 1'b1);
        add_item(CH_UP_A - 8'd1, 1'b0);
        add_item(CH_UP_Z + 8'd1, 1'b0);
        add_item(CH_LO_A - 8'd1, 1'b0);
        add_item(CH_LO_Z + 8'd1, 1'b0);
        add_item(CH_RPAREN, 1'b1);

        // random: one guaranteed overflow, then mostly well-formed expressions
        add_deep_nest(17, 20);
        while (counted_items < RANDOM_ITEMS)
        begin
            choice = $urandom_range(0, 99);
            if (choice < 4)
                add_deep_nest(8, 20);
            else if (choice < 75)
                add_expression();
            else
                add_noise();
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_chars.size() != 0 || s_tvalid)
            @(posedge clk);
        for (drain = 0; drain < DRAIN_LIMIT && expected_symbols.size() != 0; drain++)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (expected_symbols.size() != 0)
        begin
            $display("%0d expected results never arrived", expected_symbols.size());
            error_count += expected_symbols.size();
        end

        $display("converted %0d expressions, checked %0d output transfers",
                 expressions_done, symbols_checked);
        $display("stack overflows hit %0d times, stray closing parens %0d times",
                 overflow_hits, unmatched_hits);
        if (error_count == 0)
            $display("infix_to_postfix_converter_test: clean");
        else
            $display("infix_to_postfix_converter_test: errors");
        $finish;
    end

    // watchdog
    initial
    begin
        #20_000_000;
        $display("timeout with %0d results outstanding", expected_symbols.size());
        $display("infix_to_postfix_converter_test: errors");
        $finish;
    end

endmodule

@@ infix_to_postfix_converter.f @@
+incdir+sv
sv/itp_pkg.sv
sv/itp_cell.sv
sv/itp_ctrl.sv
sv/infix_to_postfix_converter.sv
sv/itp_checker.sv
dv/infix_to_postfix_converter_test.sv
